@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the checker module of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk that is switched off while reset is held.
`define BDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that is also checked while reset is held.
`define BDE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bde_pkg.sv @@
// ---------------------------------------------------------------------------
// bde_pkg
// Types and constants shared by the bit deposit / extract unit.
// ---------------------------------------------------------------------------
package bde_pkg;

  // Width of the source, mask and result ports.
  localparam int unsigned DATA_W = 64;

  // Operation selected by one input beat.
  typedef enum logic {
    KIND_DEPOSIT = 1'b0,
    KIND_EXTRACT = 1'b1
  } kind_t;

endpackage

@@ rtl/bde_prefix.sv @@
// ---------------------------------------------------------------------------
// bde_prefix
// Exclusive prefix population count of the mask: for every bit position it
// gives the number of set mask bits strictly below it. Built as a
// log-depth parallel prefix adder network.
// ---------------------------------------------------------------------------
module bde_prefix #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]                        msk,
  output logic [WORD_BITS-1:0][$clog2(WORD_BITS)-1:0] cnt
);

  localparam int unsigned CNT_W  = $clog2(WORD_BITS);
  localparam int unsigned LEVELS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0][CNT_W-1:0] lvl [LEVELS+1];

  // Seed each position with the mask bit just below it, then combine
  // partial sums at doubling distances.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      if (i == 0) begin
        lvl[0][i] = '0;
      end else begin
        lvl[0][i] = CNT_W'(msk[i-1]);
      end
    end
    for (int s = 0; s < LEVELS; s++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (i >= (1 << s)) begin
          lvl[s+1][i] = lvl[s][i] + lvl[s][i-(1<<s)];
        end else begin
          lvl[s+1][i] = lvl[s][i];
        end
      end
    end
  end

  assign cnt = lvl[LEVELS];

endmodule

@@ rtl/bde_route.sv @@
// ---------------------------------------------------------------------------
// bde_route
// Bit routing crossbar. Deposit picks, for each set mask position, the
// source bit whose index is the prefix count there. Extract sends each
// selected source bit to the output position equal to its prefix count.
// ---------------------------------------------------------------------------
module bde_route #(
  parameter int unsigned WORD_BITS = 64
) (
  input  bde_pkg::kind_t                              kind,
  input  logic [WORD_BITS-1:0]                        src,
  input  logic [WORD_BITS-1:0]                        msk,
  input  logic [WORD_BITS-1:0][$clog2(WORD_BITS)-1:0] cnt,
  output logic [WORD_BITS-1:0]                        result
);

  import bde_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] dep_res;
  logic [WORD_BITS-1:0] ext_res;
  logic [WORD_BITS-1:0] sel_bits;
  logic [WORD_BITS-1:0] hit;

  // Deposit: one source multiplexer per result bit.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      dep_res[i] = msk[i] & src[cnt[i]];
    end
  end

  // Extract: each output bit ORs the selected source bits whose rank matches.
  assign sel_bits = src & msk;

  always_comb begin
    hit = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        hit[i] = sel_bits[i] & (cnt[i] == CNT_W'(k));
      end
      ext_res[k] = |hit;
    end
  end

  assign result = (kind == KIND_EXTRACT) ? ext_res : dep_res;

endmodule

@@ rtl/bit_deposit_extract_unit.sv @@
// ---------------------------------------------------------------------------
// bit_deposit_extract_unit
// 64-bit parallel bit deposit (scatter) and extract (gather) unit.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+----------------------------------
//   in_     | input     | in_valid/in_stall  | in_kind, in_source, in_select_mask
//   out_    | output    | out_valid/out_stall| out_result
//
// While in_ does not stall, one beat is accepted per cycle; its result passes
// through the input register, then prefix count and crossbar into the result
// register; a new beat can enter before the last one has left. A stall on out_
// holds the result; in_ stalls only once both stages are full and out_ stalls.
// Reset (rst_n low, synchronous) empties both stages; no data is kept.
// ---------------------------------------------------------------------------
module bit_deposit_extract_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bde_pkg::kind_t              in_kind,
  input  logic [bde_pkg::DATA_W-1:0]  in_source,
  input  logic [bde_pkg::DATA_W-1:0]  in_select_mask,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bde_pkg::DATA_W-1:0]  out_result
);

  import bde_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_BITS);

  logic                             in_vld_r;
  logic                             out_vld_r;
  kind_t                            kind_r;
  logic [WORD_BITS-1:0]             src_r;
  logic [WORD_BITS-1:0]             msk_r;
  logic [DATA_W-1:0]                result_r;
  logic [WORD_BITS-1:0][CNT_W-1:0]  cnt;
  logic [WORD_BITS-1:0]             route_res;
  logic                             adv_out;
  logic                             adv_in;

  // Flow control: a stage loads when it is empty or drains in the same cycle.
  assign adv_out  = !out_vld_r || !out_stall;
  assign adv_in   = !in_vld_r || adv_out;
  assign in_stall = !adv_in;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_r <= in_valid;
      end
      if (adv_out) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // Input register; only the low WORD_BITS bits take part.
  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      kind_r <= in_kind;
      src_r  <= in_source[WORD_BITS-1:0];
      msk_r  <= in_select_mask[WORD_BITS-1:0];
    end
  end

  // Rank of every mask bit.
  bde_prefix #(
    .WORD_BITS (WORD_BITS)
  ) u_prefix (
    .msk (msk_r),
    .cnt (cnt)
  );

  // Scatter or gather crossbar.
  bde_route #(
    .WORD_BITS (WORD_BITS)
  ) u_route (
    .kind   (kind_r),
    .src    (src_r),
    .msk    (msk_r),
    .cnt    (cnt),
    .result (route_res)
  );

  // Result register; bits above WORD_BITS stay zero.
  always_ff @(posedge clk) begin
    if (adv_out && in_vld_r) begin
      result_r <= DATA_W'(route_res);
    end
  end

  assign out_valid  = out_vld_r;
  assign out_result = result_r;

endmodule

@@ rtl/bde_checker.sv @@
// ---------------------------------------------------------------------------
// bde_checker
// Port-level checks for the bit deposit / extract unit, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bde_checker #(
  parameter int unsigned WORD_BITS = 64
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bde_pkg::DATA_W-1:0]  out_result
);

  import bde_pkg::*;

  localparam logic [DATA_W-1:0] WORD_MASK =
    (WORD_BITS >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << WORD_BITS) - DATA_W'(1));

  // A stalled result beat stays offered and unchanged.
  `BDE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "out_valid dropped under stall")
  `BDE_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_result), "out_result changed under stall")

  // The input side only stalls when a result is waiting and blocked.
  `BDE_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with free pipeline")

  // Result bits above the configured word width are always clear.
  `BDE_ASSERT(a_high_zero, out_valid |-> (out_result & ~WORD_MASK) == '0, "high result bits set")

  // Reset empties the result stage.
  `BDE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind bit_deposit_extract_unit bde_checker #(
  .WORD_BITS (WORD_BITS)
) u_bde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_result (out_result)
);
